>>> src/ipfe_pkg.sv
// Shared types, constants and helpers for the IPv4 forwarding engine.
`default_nettype none
package ipfe_pkg;

  localparam int ROUTE_ENTRIES = 64;
  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

  localparam logic OP_ADD_ROUTE = 1'b0;
  localparam logic OP_HDR_WORD  = 1'b1;

  localparam logic [1:0] ACT_LOCAL    = 2'd0;
  localparam logic [1:0] ACT_FORWARD  = 2'd1;
  localparam logic [1:0] ACT_TTL_ERR  = 2'd2;
  localparam logic [1:0] ACT_NO_ROUTE = 2'd3;

  localparam logic [3:0] WIDX_FIRST = 4'd0;
  localparam logic [3:0] WIDX_TTL   = 4'd2;
  localparam logic [3:0] WIDX_DST   = 4'd4;
  localparam logic [3:0] IHL_MIN    = 4'd5;
  localparam logic [5:0] MASK_MAX   = 6'd32;

  typedef struct packed {
    logic [31:0] dest;
    logic [5:0]  len;
    logic [31:0] hop;
  } route_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       rd_start;
    logic       rd_next;
    logic       emit;
    logic [1:0] emit_action;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hdr_last;
    logic ttl_zero;
    logic is_local;
    logic table_empty;
    logic hit;
    logic last_entry;
  } dp_status_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else begin
      m = 32'hFFFF_FFFF << (MASK_MAX - len);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> src/ipfe_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ipfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> src/ipfe_ctrl.sv
// Controller FSM: header intake, verdict decision and route table walk.
`default_nettype none
module ipfe_ctrl import ipfe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t st,
  output ctrl_cmd_t       cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    busy            = (state_r != ST_IDLE);
    cmd             = '0;
    cmd.accept      = start && (state_r == ST_IDLE);
    cmd.emit_action = ACT_NO_ROUTE;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && st.hdr_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (st.ttl_zero) begin
          cmd.emit        = 1'b1;
          cmd.emit_action = ACT_TTL_ERR;
          state_nxt       = ST_IDLE;
        end else if (st.is_local) begin
          cmd.emit        = 1'b1;
          cmd.emit_action = ACT_LOCAL;
          state_nxt       = ST_IDLE;
        end else if (st.table_empty) begin
          cmd.emit        = 1'b1;
          cmd.emit_action = ACT_NO_ROUTE;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.rd_start = 1'b1;
          state_nxt    = ST_WALK;
        end
      end
      ST_WALK: begin
        priority if (st.hit) begin
          cmd.emit        = 1'b1;
          cmd.emit_action = ACT_FORWARD;
          state_nxt       = ST_IDLE;
        end else if (st.last_entry) begin
          cmd.emit        = 1'b1;
          cmd.emit_action = ACT_NO_ROUTE;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

>>> src/ipfe_dp.sv
// Datapath: route table, header checksum fold, held fields and result registers.
`default_nettype none
module ipfe_dp import ipfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctrl_cmd_t   cmd,
  output dp_status_t       st,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_op,
  input  wire logic [31:0] in_data_word,
  input  wire logic [5:0]  in_route_mask_len,
  input  wire logic [31:0] in_route_next_hop,
  output logic             out_valid,
  output logic [1:0]       out_action,
  output logic [31:0]      out_next_hop,
  output logic [7:0]       out_new_ttl,
  output logic [15:0]      out_new_checksum
);
  logic [31:0]      local_addr_r;
  logic [CNT_W-1:0] route_count_r, route_count_nxt;
  logic [3:0]       word_index_r, word_index_nxt;
  logic [3:0]       header_len_r, header_len_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       held_ttl_r, held_ttl_nxt;
  logic [31:0]      held_dest_r, held_dest_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             out_valid_r;
  logic [1:0]       out_action_r;
  logic [31:0]      out_next_hop_r;
  logic [7:0]       out_new_ttl_r;
  logic [15:0]      out_new_checksum_r;

  // route table
  logic       add_we;
  route_t     add_entry;
  logic       rd_en;
  route_t     rd_entry;
  logic [$bits(route_t)-1:0] rd_raw;

  // header word handling
  logic        hdr_acc;
  logic [3:0]  ihl_eff;
  logic [3:0]  hl_eff;
  logic [3:0]  idx_inc;
  logic [31:0] word_mod;
  logic [15:0] sum_base;
  logic [17:0] acc0;
  logic [16:0] acc1;
  logic [31:0] mask;

  assign add_we = cmd.accept && (in_op == OP_ADD_ROUTE) &&
                  (route_count_r < CNT_W'(ROUTE_ENTRIES));
  assign add_entry.dest = in_data_word;
  assign add_entry.len  = (in_route_mask_len > MASK_MAX) ? MASK_MAX : in_route_mask_len;
  assign add_entry.hop  = in_route_next_hop;

  assign rd_en      = cmd.rd_start || cmd.rd_next;
  assign rd_idx_nxt = cmd.rd_start ? '0 : (cmd.rd_next ? rd_idx_r + 1'b1 : rd_idx_r);

  ipfe_ram #(
    .WIDTH ($bits(route_t)),
    .DEPTH (ROUTE_ENTRIES)
  ) u_route_ram (
    .clk   (clk),
    .we    (add_we),
    .waddr (route_count_r[IDX_W-1:0]),
    .wdata (add_entry),
    .re    (rd_en),
    .raddr (rd_idx_nxt),
    .rdata (rd_raw)
  );
  assign rd_entry = route_t'(rd_raw);

  always_comb begin
    hdr_acc         = cmd.accept && (in_op == OP_HDR_WORD);
    ihl_eff         = (in_data_word[27:24] < IHL_MIN) ? IHL_MIN : in_data_word[27:24];
    hl_eff          = (word_index_r == WIDX_FIRST) ? ihl_eff : header_len_r;
    sum_base        = (word_index_r == WIDX_FIRST) ? 16'd0 : sum_r;
    word_mod        = in_data_word;
    held_ttl_nxt    = held_ttl_r;
    held_dest_nxt   = held_dest_r;
    if (word_index_r == WIDX_TTL) begin
      held_ttl_nxt = in_data_word[31:24];
      // TTL already decremented, checksum field zeroed
      word_mod = {in_data_word[31:24] - 8'd1, in_data_word[23:16], 16'd0};
    end
    if (word_index_r == WIDX_DST) begin
      held_dest_nxt = in_data_word;
    end
    acc0    = {2'b00, sum_base} + {2'b00, word_mod[31:16]} + {2'b00, word_mod[15:0]};
    acc1    = {1'b0, acc0[15:0]} + {15'd0, acc0[17:16]};
    sum_nxt = acc1[15:0] + {15'd0, acc1[16]};
    idx_inc = word_index_r + 4'd1;

    st.hdr_last = hdr_acc && !(idx_inc < hl_eff);

    word_index_nxt  = word_index_r;
    header_len_nxt  = header_len_r;
    if (hdr_acc) begin
      word_index_nxt = st.hdr_last ? WIDX_FIRST : idx_inc;
      header_len_nxt = hl_eff;
    end else begin
      sum_nxt       = sum_r;
      held_ttl_nxt  = held_ttl_r;
      held_dest_nxt = held_dest_r;
    end

    route_count_nxt = add_we ? route_count_r + 1'b1 : route_count_r;

    mask           = prefix_mask(rd_entry.len);
    st.ttl_zero    = (held_ttl_r == 8'd0);
    st.is_local    = (held_dest_r == local_addr_r);
    st.table_empty = (route_count_r == '0);
    st.hit         = ((rd_entry.dest & mask) == (held_dest_r & mask));
    st.last_entry  = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == route_count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r  <= '0;
      route_count_r <= '0;
      word_index_r  <= '0;
      header_len_r  <= '0;
      sum_r         <= '0;
      held_ttl_r    <= '0;
      held_dest_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        local_addr_r <= cfg_wdata;
      end
      route_count_r <= route_count_nxt;
      word_index_r  <= word_index_nxt;
      header_len_r  <= header_len_nxt;
      sum_r         <= sum_nxt;
      held_ttl_r    <= held_ttl_nxt;
      held_dest_r   <= held_dest_nxt;
      out_valid_r   <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    if (cmd.emit) begin
      out_action_r <= cmd.emit_action;
      if (cmd.emit_action == ACT_FORWARD) begin
        out_next_hop_r     <= rd_entry.hop;
        out_new_ttl_r      <= held_ttl_r - 8'd1;
        out_new_checksum_r <= ~sum_r;
      end else begin
        out_next_hop_r     <= '0;
        out_new_ttl_r      <= '0;
        out_new_checksum_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_next_hop     = out_next_hop_r;
  assign out_new_ttl      = out_new_ttl_r;
  assign out_new_checksum = out_new_checksum_r;
endmodule
`default_nettype wire

>>> src/ipv4_forward_engine.sv
// IPv4 forwarding engine with first-match route table: top level.
// Route add or non-final header word: accepted when idle, busy stays low.
// Final header word: busy through DECIDE (TTL/local/empty-table verdict) and then
//   through WALK until an entry hits or the last entry misses (one RAM read per cycle);
//   out_valid is registered from the emit in DECIDE or WALK.
// Worst case miss walks every stored entry. Results are never held off.
// Sync active-low reset clears control, counters and local address; table is not cleared.
`default_nettype none
module ipv4_forward_engine import ipfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // input transaction
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [31:0] in_data_word,
  input  wire logic [5:0]  in_route_mask_len,
  input  wire logic [31:0] in_route_next_hop,
  // result transaction, one-cycle strobe
  output logic             out_valid,
  output logic [1:0]       out_action,
  output logic [31:0]      out_next_hop,
  output logic [7:0]       out_new_ttl,
  output logic [15:0]      out_new_checksum
);
  ctrl_cmd_t  cmd;
  dp_status_t st;

  // controller: idle intake, decide, then walk the table in order
  ipfe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // datapath: checksum fold per word, held TTL/dest, RAM, result regs
  ipfe_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_op             (in_op),
    .in_data_word      (in_data_word),
    .in_route_mask_len (in_route_mask_len),
    .in_route_next_hop (in_route_next_hop),
    .out_valid         (out_valid),
    .out_action        (out_action),
    .out_next_hop      (out_next_hop),
    .out_new_ttl       (out_new_ttl),
    .out_new_checksum  (out_new_checksum)
  );
endmodule
`default_nettype wire
